/* src/oledc_pkg.sv */
package oledc_pkg;

    // Panel geometry limits and display RAM size.
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_PAGES   = 8;
    localparam int RAM_DEPTH   = MAX_COLUMNS * MAX_PAGES;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    localparam logic [7:0] COLS_HI  = 8'(MAX_COLUMNS);
    localparam logic [7:0] COLS_LO  = 8'd32;
    localparam logic [7:0] PAGES_HI = 8'(MAX_PAGES);
    localparam logic [7:0] PAGES_LO = 8'd2;

    // Configuration register indexes.
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_PAGES   = 1'b1;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_SCAN  = 2'd2;

    // Addressing modes.
    localparam logic [1:0] MODE_HORIZ = 2'd0;
    localparam logic [1:0] MODE_VERT  = 2'd1;
    localparam logic [1:0] MODE_PAGE  = 2'd2;

    // Command codes and command ranges.
    localparam logic [7:0] CMD_COL_HI_BASE  = 8'h10;
    localparam logic [7:0] CMD_LOW_END      = 8'h20;
    localparam logic [7:0] CMD_START_BASE   = 8'h40;
    localparam logic [7:0] CMD_START_LAST   = 8'h7F;
    localparam logic [7:0] CMD_PAGE_BASE    = 8'hB0;
    localparam logic [7:0] CMD_PAGE_LAST    = 8'hB7;
    localparam logic [7:0] CMD_ADDR_MODE    = 8'h20;
    localparam logic [7:0] CMD_COL_WINDOW   = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW  = 8'h22;
    localparam logic [7:0] CMD_HSCROLL_R    = 8'h26;
    localparam logic [7:0] CMD_HSCROLL_L    = 8'h27;
    localparam logic [7:0] CMD_VHSCROLL_R   = 8'h29;
    localparam logic [7:0] CMD_VHSCROLL_L   = 8'h2A;
    localparam logic [7:0] CMD_SCROLL_OFF   = 8'h2E;
    localparam logic [7:0] CMD_SCROLL_ON    = 8'h2F;
    localparam logic [7:0] CMD_CONTRAST     = 8'h81;
    localparam logic [7:0] CMD_CHARGE_PUMP  = 8'h8D;
    localparam logic [7:0] CMD_VSCROLL_AREA = 8'hA3;
    localparam logic [7:0] CMD_ENTIRE_OFF   = 8'hA4;
    localparam logic [7:0] CMD_ENTIRE_ON    = 8'hA5;
    localparam logic [7:0] CMD_NORMAL       = 8'hA6;
    localparam logic [7:0] CMD_INVERT       = 8'hA7;
    localparam logic [7:0] CMD_MUX_RATIO    = 8'hA8;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'hAE;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;
    localparam logic [7:0] CMD_COM_NORMAL   = 8'hC0;
    localparam logic [7:0] CMD_COM_REVERSE  = 8'hC8;
    localparam logic [7:0] CMD_OFFSET       = 8'hD3;
    localparam logic [7:0] CMD_CLOCK_DIV    = 8'hD5;
    localparam logic [7:0] CMD_PRECHARGE    = 8'hD9;
    localparam logic [7:0] CMD_COM_PINS     = 8'hDA;
    localparam logic [7:0] CMD_VCOMH        = 8'hDB;

    localparam logic [5:0] MUX_MIN   = 6'd15;
    localparam logic [5:0] MUX_RESET = 6'd63;

    // Architectural state of the decoder.
    typedef struct packed {
        logic [6:0] col_ptr;
        logic [2:0] page_ptr;
        logic [6:0] col_start;
        logic [6:0] col_end;
        logic [2:0] page_start;
        logic [2:0] page_end;
        logic [1:0] addr_mode;
        logic       expect_control;
        logic       data_phase;
        logic [7:0] pending_cmd;
        logic [2:0] param_total;
        logic [2:0] param_index;
        logic       display_on;
        logic       entire_on;
        logic       inverted;
        logic       scan_reversed;
        logic       scroll_active;
        logic [5:0] start_line;
        logic [5:0] mux_ratio;
        logic [5:0] display_offset;
    } t_regs;

    // One display RAM write request.
    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    // Register file return to defaults, as done by the display off command.
    // Transaction state, pending command and display offset are kept.
    function automatic t_regs f_regs_reset(input t_regs cur, input logic [7:0] cols,
                                           input logic [3:0] pages);
        t_regs r;
        logic [7:0] ce;
        logic [3:0] pe;
        r             = cur;
        ce            = cols - 8'd1;
        pe            = pages - 4'd1;
        r.mux_ratio   = MUX_RESET;
        r.start_line  = '0;
        r.col_ptr     = '0;
        r.page_ptr    = '0;
        r.col_start   = '0;
        r.col_end     = ce[6:0];
        r.page_start  = '0;
        r.page_end    = pe[2:0];
        r.param_total = '0;
        r.display_on  = 1'b0;
        r.entire_on   = 1'b0;
        r.inverted    = 1'b0;
        r.scan_reversed = 1'b0;
        r.scroll_active = 1'b0;
        r.addr_mode   = MODE_PAGE;
        return r;
    endfunction

endpackage

/* src/oledc_ram.sv */
module oledc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/oledc_decode.sv */
module oledc_decode
    import oledc_pkg::*;
(
    input  t_regs       i_regs,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_cols,
    input  logic [3:0]  i_pages,
    output t_regs       o_regs,
    output logic        o_err,
    output t_ram_wr     o_wr
);

    logic [7:0] col_inc;
    logic [3:0] page_inc;
    logic [6:0] adv_col;
    logic [2:0] adv_page;
    logic [2:0] pidx_next;

    // Write pointer advance after a data byte.
    always_comb begin
        col_inc  = {1'b0, i_regs.col_ptr} + 8'd1;
        page_inc = {1'b0, i_regs.page_ptr} + 4'd1;
        adv_col  = i_regs.col_ptr;
        adv_page = i_regs.page_ptr;
        if (i_regs.addr_mode == MODE_VERT) begin
            if (page_inc > {1'b0, i_regs.page_end}) begin
                adv_page = i_regs.page_start;
                if (col_inc > {1'b0, i_regs.col_end}) begin
                    adv_col = i_regs.col_start;
                end else begin
                    adv_col = col_inc[6:0];
                end
            end else begin
                adv_page = page_inc[2:0];
            end
        end else begin
            if (col_inc > {1'b0, i_regs.col_end}) begin
                adv_col = i_regs.col_start;
                if (i_regs.addr_mode == MODE_HORIZ) begin
                    if (page_inc > {1'b0, i_regs.page_end}) begin
                        adv_page = i_regs.page_start;
                    end else begin
                        adv_page = page_inc[2:0];
                    end
                end
            end else begin
                adv_col = col_inc[6:0];
            end
        end
    end

    assign pidx_next = i_regs.param_index + 3'd1;

    always_comb begin
        o_regs     = i_regs;
        o_err      = 1'b0;
        o_wr.en    = 1'b0;
        o_wr.addr  = RAM_AW'({i_regs.col_ptr, i_regs.page_ptr});
        o_wr.data  = i_byte;
        case (i_func)
            FUNC_START: begin
                o_regs.expect_control = 1'b1;
            end
            FUNC_BYTE: begin
                if (i_regs.expect_control) begin
                    if (i_byte[5:0] != 6'd0) begin
                        o_err = 1'b1;
                    end else begin
                        o_regs.expect_control = i_byte[7];
                        o_regs.data_phase     = i_byte[6];
                    end
                end else if (i_regs.data_phase) begin
                    o_wr.en         = 1'b1;
                    o_regs.col_ptr  = adv_col;
                    o_regs.page_ptr = adv_page;
                end else if (i_regs.param_total != 3'd0) begin
                    // Parameter byte of the pending command.
                    o_regs.param_index = pidx_next;
                    if (pidx_next <= i_regs.param_total) begin
                        if (pidx_next == i_regs.param_total) begin
                            o_regs.param_total = '0;
                        end
                        case (i_regs.pending_cmd)
                            CMD_ADDR_MODE: o_regs.addr_mode = i_byte[1:0];
                            CMD_COL_WINDOW: begin
                                if (i_regs.addr_mode != MODE_PAGE) begin
                                    if (pidx_next == 3'd1) begin
                                        o_regs.col_start = i_byte[6:0];
                                    end else begin
                                        o_regs.col_end = i_byte[6:0];
                                    end
                                end
                            end
                            CMD_PAGE_WINDOW: begin
                                if (i_regs.addr_mode != MODE_PAGE) begin
                                    if (pidx_next == 3'd1) begin
                                        o_regs.page_start = i_byte[2:0];
                                    end else begin
                                        o_regs.page_end = i_byte[2:0];
                                    end
                                end
                            end
                            CMD_MUX_RATIO: begin
                                if (i_byte[5:0] >= MUX_MIN) begin
                                    o_regs.mux_ratio = i_byte[5:0];
                                end
                            end
                            CMD_OFFSET: o_regs.display_offset = i_byte[5:0];
                            default: ;
                        endcase
                    end
                end else begin
                    // New command byte.
                    o_regs.pending_cmd = i_byte;
                    o_regs.param_index = '0;
                    o_regs.param_total = '0;
                    if (i_byte < CMD_LOW_END) begin
                        if (i_regs.addr_mode == MODE_PAGE) begin
                            if (i_byte < CMD_COL_HI_BASE) begin
                                o_regs.col_ptr = {i_regs.col_ptr[6:4], i_byte[3:0]};
                            end else begin
                                o_regs.col_ptr = {i_byte[2:0], i_regs.col_ptr[3:0]};
                            end
                        end
                    end else if (i_byte >= CMD_START_BASE && i_byte <= CMD_START_LAST) begin
                        o_regs.start_line = i_byte[5:0];
                    end else if (i_byte >= CMD_PAGE_BASE && i_byte <= CMD_PAGE_LAST) begin
                        if (i_regs.addr_mode == MODE_PAGE) begin
                            o_regs.page_ptr = i_byte[2:0];
                        end
                    end else begin
                        case (i_byte)
                            CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MUX_RATIO,
                            CMD_OFFSET, CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_COM_PINS,
                            CMD_VCOMH: o_regs.param_total = 3'd1;
                            CMD_COL_WINDOW, CMD_PAGE_WINDOW, CMD_VSCROLL_AREA:
                                o_regs.param_total = 3'd2;
                            CMD_HSCROLL_R, CMD_HSCROLL_L: o_regs.param_total = 3'd6;
                            CMD_VHSCROLL_R, CMD_VHSCROLL_L: o_regs.param_total = 3'd5;
                            CMD_SCROLL_OFF: o_regs.scroll_active = 1'b0;
                            CMD_SCROLL_ON: o_regs.scroll_active = 1'b1;
                            CMD_ENTIRE_OFF: o_regs.entire_on = 1'b0;
                            CMD_ENTIRE_ON: o_regs.entire_on = 1'b1;
                            CMD_NORMAL: o_regs.inverted = 1'b0;
                            CMD_INVERT: o_regs.inverted = 1'b1;
                            CMD_DISPLAY_OFF: o_regs = f_regs_reset(o_regs, i_cols, i_pages);
                            CMD_DISPLAY_ON: o_regs.display_on = 1'b1;
                            CMD_COM_NORMAL: o_regs.scan_reversed = 1'b0;
                            CMD_COM_REVERSE: o_regs.scan_reversed = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

/* src/oled_controller_command_decoder_unit.sv */
// Channel     | Direction | Signals                                | Contents
// ------------+-----------+----------------------------------------+---------------------------
// input items | in        | s_tvalid, s_tready, s_tdata, s_tuser   | serial byte or scan read
// result items| out       | m_tvalid, m_tready, m_tdata            | read byte, error, status
// config      | in        | i_cfg_we, i_cfg_idx, i_cfg_data        | panel columns and pages
//
// The block takes one item per clock unless its output stalls or the clearing pass runs,
// and returns its result in the next cycle from the result register; the rate is set by
// the single decode pass between the input handshake and that register. A stalled output
// holds the result, and a new item is taken in the same cycle that the held result is
// taken. After reset a clearing pass writes zero to all 1024 display RAM bytes, one byte a
// cycle, and no item is taken until it ends; configuration writes are taken at any time.
module oled_controller_command_decoder_unit
    import oledc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: rx_byte [7:0], scan_column [14:8], scan_page [17:15], zero fill [23:18].
    input  logic [23:0] s_tdata,
    // s_tuser: func [1:0].
    input  logic [1:0]  s_tuser,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: read_data [7:0], control_error [8], display_on [9], entire_on [10],
    // inverted [11], scan_reversed [12], start_line [18:13], mux_ratio [24:19],
    // display_offset [30:25], scroll_active [31], column_pointer [38:32],
    // page_pointer [41:39], zero fill [47:42].
    output logic [47:0] m_tdata,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    // Configuration registers, clamped when written.
    logic [7:0]        r_cols;
    logic [3:0]        r_pages;
    logic [7:0]        n_cols;
    logic [3:0]        n_pages;

    // Decoder state and its next value for the item being taken.
    t_regs             r_regs;
    t_regs             n_regs;
    t_regs             reset_regs;
    logic              dec_err;
    t_ram_wr           dec_wr;

    // Clearing pass over the display RAM after reset.
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;

    // Result register. The read byte itself comes from the RAM's read register.
    logic              r_out_valid;
    logic              r_out_read;
    logic              r_out_err;
    t_regs             r_out_regs;

    logic              accept;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    logic [1:0]        in_func;
    logic [7:0]        in_byte;
    logic [6:0]        in_scan_col;
    logic [2:0]        in_scan_page;
    logic [7:0]        read_byte;
    logic [7:0]        cols_dec;

    assign in_func      = s_tuser;
    assign in_byte      = s_tdata[7:0];
    assign in_scan_col  = s_tdata[14:8];
    assign in_scan_page = s_tdata[17:15];

    // An item is taken when not clearing and the result register is free or being emptied.
    assign s_tready = !r_clr_busy && (!r_out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        n_cols = i_cfg_data;
        if (i_cfg_data > COLS_HI) begin
            n_cols = COLS_HI;
        end else if (i_cfg_data < COLS_LO) begin
            n_cols = COLS_LO;
        end
        n_pages = i_cfg_data[3:0];
        if (i_cfg_data > PAGES_HI) begin
            n_pages = PAGES_HI[3:0];
        end else if (i_cfg_data < PAGES_LO) begin
            n_pages = PAGES_LO[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= COLS_HI;
            r_pages <= PAGES_HI[3:0];
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_cols  <= n_cols;
                CFG_PAGES:   r_pages <= n_pages;
                default: ;
            endcase
        end
    end

    // Power-on state: defaults everywhere with the transaction state idle.
    assign cols_dec = COLS_HI - 8'd1;
    always_comb begin
        reset_regs                = '0;
        reset_regs.col_end        = cols_dec[6:0];
        reset_regs.page_end       = 3'(MAX_PAGES - 1);
        reset_regs.addr_mode      = MODE_PAGE;
        reset_regs.mux_ratio      = MUX_RESET;
    end

    oledc_decode u_decode (
        .i_regs  (r_regs),
        .i_func  (in_func),
        .i_byte  (in_byte),
        .i_cols  (r_cols),
        .i_pages (r_pages),
        .o_regs  (n_regs),
        .o_err   (dec_err),
        .o_wr    (dec_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= reset_regs;
        end else if (accept) begin
            r_regs <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + RAM_AW'(1);
            if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // The clearing pass owns the write port until it ends; no item is taken meanwhile.
    assign ram_we    = r_clr_busy || (accept && dec_wr.en);
    assign ram_waddr = r_clr_busy ? r_clr_addr : dec_wr.addr;
    assign ram_wdata = r_clr_busy ? 8'd0 : dec_wr.data;
    // The read register only loads for a scan item, so it holds while the result stalls.
    assign ram_re    = accept && (in_func == FUNC_SCAN);

    oledc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (RAM_AW'({in_scan_col, in_scan_page})),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_read <= (in_func == FUNC_SCAN);
            r_out_err  <= dec_err;
            r_out_regs <= n_regs;
        end
    end

    assign read_byte = r_out_read ? ram_rdata : 8'd0;
    assign m_tvalid  = r_out_valid;
    assign m_tdata   = {6'd0,
                        r_out_regs.page_ptr,
                        r_out_regs.col_ptr,
                        r_out_regs.scroll_active,
                        r_out_regs.display_offset,
                        r_out_regs.mux_ratio,
                        r_out_regs.start_line,
                        r_out_regs.scan_reversed,
                        r_out_regs.inverted,
                        r_out_regs.entire_on,
                        r_out_regs.display_on,
                        r_out_err,
                        read_byte};

endmodule

/* tb/sv/testbench.sv */
module testbench
    import oledc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Item kind that the block does not define; it must change nothing.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Control byte fields. Bit 7 keeps the decoder on control bytes, bit 6
    // selects the data phase, and the low six bits are reserved.
    localparam logic [7:0] CTRL_COMMAND  = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] CTRL_CONTINUE = 8'h80;
    localparam logic [7:0] CTRL_RESERVED = 8'h3F;

    // A command byte that the decoder does not know.
    localparam logic [7:0] CMD_UNKNOWN = 8'hFF;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 6;
    localparam int LONG_HOLD       = 400;

    // One result item, laid out exactly as m_tdata (last member in the lowest bits).
    typedef struct packed {
        logic [5:0] fill;
        logic [2:0] page_pointer;
        logic [6:0] column_pointer;
        logic       scroll_active;
        logic [5:0] display_offset;
        logic [5:0] mux_ratio;
        logic [5:0] start_line;
        logic       scan_reversed;
        logic       inverted;
        logic       entire_on;
        logic       display_on;
        logic       control_error;
        logic [7:0] read_data;
    } t_panel_status;

    // Mirror of the decoder: it keeps its own copy of the display RAM, the write
    // pointers, the window, the transaction state and the status registers, works
    // out the status item for every accepted input item, and compares the items
    // that come out of the block against that list in order.
    class t_panel_status_board;
        logic [7:0] pixel_ram [RAM_DEPTH];
        logic [7:0] cols_in_use;
        logic [7:0] pages_in_use;
        logic [6:0] col_ptr;
        logic [6:0] col_start;
        logic [6:0] col_end;
        logic [2:0] page_ptr;
        logic [2:0] page_start;
        logic [2:0] page_end;
        logic [1:0] addr_mode;
        logic       expect_ctrl;
        logic       data_phase;
        logic [7:0] pending_cmd;
        logic [2:0] param_total;
        logic [2:0] param_index;
        logic       display_on;
        logic       entire_on;
        logic       inverted;
        logic       scan_reversed;
        logic       scroll_active;
        logic [5:0] start_line;
        logic [5:0] mux_ratio;
        logic [5:0] display_offset;
        t_panel_status status_q[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            cols_in_use  = COLS_HI;
            pages_in_use = PAGES_HI;
            foreach (pixel_ram[i]) pixel_ram[i] = '0;
            restore_defaults();
            expect_ctrl    = 1'b0;
            data_phase     = 1'b0;
            pending_cmd    = '0;
            param_index    = '0;
            display_offset = '0;
            mismatches     = 0;
            results_seen   = 0;
        endfunction

        // Panel size writes are clamped to the legal range and only take effect
        // on the window bounds at the next display off command.
        function void set_size(logic idx, logic [7:0] value);
            logic [7:0] v;
            v = value;
            if (idx == CFG_COLUMNS) begin
                if (v > COLS_HI) v = COLS_HI;
                if (v < COLS_LO) v = COLS_LO;
                cols_in_use = v;
            end else begin
                if (v > PAGES_HI) v = PAGES_HI;
                if (v < PAGES_LO) v = PAGES_LO;
                pages_in_use = v;
            end
        endfunction

        // Display off: registers go back to defaults, but the RAM, the display
        // offset, the transaction state and the pending command are kept.
        function void restore_defaults();
            logic [7:0] ce;
            logic [7:0] pe;
            ce            = cols_in_use - 8'd1;
            pe            = pages_in_use - 8'd1;
            mux_ratio     = MUX_RESET;
            start_line    = '0;
            col_ptr       = '0;
            page_ptr      = '0;
            col_start     = '0;
            col_end       = ce[6:0];
            page_start    = '0;
            page_end      = pe[2:0];
            param_total   = '0;
            display_on    = 1'b0;
            entire_on     = 1'b0;
            inverted      = 1'b0;
            scan_reversed = 1'b0;
            scroll_active = 1'b0;
            addr_mode     = MODE_PAGE;
        endfunction

        // A data byte lands at the write pointer, which then advances. Any value
        // past the end bound wraps to the start bound.
        function void store_data(logic [7:0] b);
            int unsigned c;
            int unsigned p;
            pixel_ram[{col_ptr, page_ptr}] = b;
            if (addr_mode == MODE_VERT) begin
                p = 32'(page_ptr) + 1;
                if (p > 32'(page_end)) begin
                    p = 32'(page_start);
                    c = 32'(col_ptr) + 1;
                    if (c > 32'(col_end)) c = 32'(col_start);
                    col_ptr = c[6:0];
                end
                page_ptr = p[2:0];
            end else begin
                c = 32'(col_ptr) + 1;
                if (c > 32'(col_end)) begin
                    col_ptr = col_start;
                    // Page mode and the spare mode stay on the same page.
                    if (addr_mode == MODE_HORIZ) begin
                        p = 32'(page_ptr) + 1;
                        if (p > 32'(page_end)) p = 32'(page_start);
                        page_ptr = p[2:0];
                    end
                end else begin
                    col_ptr = c[6:0];
                end
            end
        endfunction

        function void take_command(logic [7:0] b);
            pending_cmd = b;
            param_index = '0;
            param_total = '0;
            if (b < CMD_LOW_END) begin
                // Column nibbles; the top bit of the high nibble has no room.
                if (addr_mode == MODE_PAGE) begin
                    if (b < CMD_COL_HI_BASE) col_ptr[3:0] = b[3:0];
                    else col_ptr[6:4] = b[2:0];
                end
            end else if (b >= CMD_START_BASE && b <= CMD_START_LAST) begin
                start_line = b[5:0];
            end else if (b >= CMD_PAGE_BASE && b <= CMD_PAGE_LAST) begin
                if (addr_mode == MODE_PAGE) page_ptr = b[2:0];
            end else begin
                case (b)
                    CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MUX_RATIO, CMD_OFFSET,
                    CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOMH: param_total = 3'd1;
                    CMD_COL_WINDOW, CMD_PAGE_WINDOW, CMD_VSCROLL_AREA: param_total = 3'd2;
                    CMD_HSCROLL_R, CMD_HSCROLL_L: param_total = 3'd6;
                    CMD_VHSCROLL_R, CMD_VHSCROLL_L: param_total = 3'd5;
                    CMD_SCROLL_OFF: scroll_active = 1'b0;
                    CMD_SCROLL_ON: scroll_active = 1'b1;
                    CMD_ENTIRE_OFF: entire_on = 1'b0;
                    CMD_ENTIRE_ON: entire_on = 1'b1;
                    CMD_NORMAL: inverted = 1'b0;
                    CMD_INVERT: inverted = 1'b1;
                    CMD_DISPLAY_OFF: restore_defaults();
                    CMD_DISPLAY_ON: display_on = 1'b1;
                    CMD_COM_NORMAL: scan_reversed = 1'b0;
                    CMD_COM_REVERSE: scan_reversed = 1'b1;
                    default: ;
                endcase
            end
        endfunction

        // Scroll setup and the analog settings are collected but never show up
        // in a result item, so only their parameter count matters here.
        function void take_parameter(logic [7:0] b);
            param_index = param_index + 3'd1;
            if (param_index > param_total) return;
            if (param_index == param_total) param_total = '0;
            case (pending_cmd)
                CMD_ADDR_MODE: addr_mode = b[1:0];
                CMD_COL_WINDOW: begin
                    if (addr_mode != MODE_PAGE) begin
                        if (param_index == 3'd1) col_start = b[6:0];
                        else col_end = b[6:0];
                    end
                end
                CMD_PAGE_WINDOW: begin
                    if (addr_mode != MODE_PAGE) begin
                        if (param_index == 3'd1) page_start = b[2:0];
                        else page_end = b[2:0];
                    end
                end
                CMD_MUX_RATIO: if (b[5:0] >= MUX_MIN) mux_ratio = b[5:0];
                CMD_OFFSET: display_offset = b[5:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] func, logic [7:0] b, logic [6:0] col,
                                logic [2:0] pg);
            t_panel_status s;
            s = '0;
            case (func)
                FUNC_START: expect_ctrl = 1'b1;
                FUNC_BYTE: begin
                    if (expect_ctrl) begin
                        // A control byte with reserved bits set is dropped.
                        if ((b & CTRL_RESERVED) != '0) begin
                            s.control_error = 1'b1;
                        end else begin
                            expect_ctrl = b[7];
                            data_phase  = b[6];
                        end
                    end else if (data_phase) begin
                        store_data(b);
                    end else if (param_total != '0) begin
                        take_parameter(b);
                    end else begin
                        take_command(b);
                    end
                end
                FUNC_SCAN: s.read_data = pixel_ram[{col, pg}];
                default: ;
            endcase
            s.display_on     = display_on;
            s.entire_on      = entire_on;
            s.inverted       = inverted;
            s.scan_reversed  = scan_reversed;
            s.start_line     = start_line;
            s.mux_ratio      = mux_ratio;
            s.display_offset = display_offset;
            s.scroll_active  = scroll_active;
            s.column_pointer = col_ptr;
            s.page_pointer   = page_ptr;
            status_q.push_back(s);
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) $display("result %0d: %s", results_seen, what);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) flag_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
        endfunction

        function void check_status(logic [47:0] d);
            t_panel_status got;
            t_panel_status want;
            got = d;
            results_seen++;
            if (status_q.size() == 0) begin
                flag_mismatch("result item with no prediction waiting");
                return;
            end
            want = status_q.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("control_error", 8'(want.control_error), 8'(got.control_error));
            compare_field("display_on", 8'(want.display_on), 8'(got.display_on));
            compare_field("entire_on", 8'(want.entire_on), 8'(got.entire_on));
            compare_field("inverted", 8'(want.inverted), 8'(got.inverted));
            compare_field("scan_reversed", 8'(want.scan_reversed), 8'(got.scan_reversed));
            compare_field("start_line", 8'(want.start_line), 8'(got.start_line));
            compare_field("mux_ratio", 8'(want.mux_ratio), 8'(got.mux_ratio));
            compare_field("display_offset", 8'(want.display_offset),
                          8'(got.display_offset));
            compare_field("scroll_active", 8'(want.scroll_active), 8'(got.scroll_active));
            compare_field("column_pointer", 8'(want.column_pointer),
                          8'(got.column_pointer));
            compare_field("page_pointer", 8'(want.page_pointer), 8'(got.page_pointer));
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    // All inputs of the block start at known values.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata    = '0;
    logic [1:0]  s_tuser    = FUNC_START;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [47:0] m_tdata;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = CFG_COLUMNS;
    logic [7:0]  i_cfg_data = '0;

    t_panel_status_board board = new();

    int items_sent   = 0;
    int send_style   = 0;
    int take_style   = 0;
    bit hold_results = 1'b0;

    oled_controller_command_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Idle cycles before an item, by style: style 0 never idles, style 1 idles
    // now and then, style 2 idles on most items. Styles are redrawn every 50 items
    // so that long stretches without idling alternate with busy, gappy ones.
    function automatic int draw_wait(int style);
        if (style == 0) return 0;
        if (style == 1) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        return $urandom_range(0, 12);
    endfunction

    // Offer one item and hold it until the block takes it. The valid is only
    // lowered for a gap, so back-to-back items keep it high without a glitch.
    task automatic send_item(logic [1:0] func, logic [7:0] b, logic [6:0] col,
                             logic [2:0] pg);
        int gap;
        if (items_sent % 50 == 0) send_style = $urandom_range(0, 2);
        gap = draw_wait(send_style);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'b0, pg, col, b};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        board.note_item(func, b, col, pg);
        items_sent++;
    endtask

    // Stop offering items and wait until every predicted result has come out.
    // Every item yields a result, so nothing is left in flight after that.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic send_start();
        send_item(FUNC_START, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                  3'($urandom_range(0, 7)));
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(FUNC_BYTE, b, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
    endtask

    // Half of the scan reads look just behind the write pointer, where data was
    // most likely written lately; the rest go anywhere in the RAM.
    task automatic send_scan();
        logic [6:0] col;
        logic [2:0] pg;
        if ($urandom_range(0, 1) == 1) begin
            col = board.col_ptr - 7'($urandom_range(0, 3));
            pg  = board.page_ptr;
        end else begin
            col = 7'($urandom_range(0, 127));
            pg  = 3'($urandom_range(0, 7));
        end
        send_item(FUNC_SCAN, 8'($urandom_range(0, 255)), col, pg);
    endtask

    // A byte inside a transaction, now and then preceded by a scan read, which
    // must not disturb the transaction state.
    task automatic send_rx(logic [7:0] b);
        if ($urandom_range(0, 9) == 0) send_scan();
        send_byte(b);
    endtask

    // Picks a command with a bias toward the ones that move the pointers and
    // the window, then sends its parameters; one in ten may be cut short.
    task automatic send_random_command();
        logic [7:0] cmd;
        logic [7:0] p;
        logic [7:0] prev;
        int         r;
        int         n;
        r    = $urandom_range(0, 99);
        prev = '0;
        if (r < 12) cmd = CMD_ADDR_MODE;
        else if (r < 20) cmd = CMD_COL_WINDOW;
        else if (r < 28) cmd = CMD_PAGE_WINDOW;
        else if (r < 36) cmd = 8'($urandom_range(0, CMD_LOW_END - 8'd1));
        else if (r < 42) cmd = 8'($urandom_range(CMD_PAGE_BASE, CMD_PAGE_LAST));
        else if (r < 48) cmd = 8'($urandom_range(CMD_START_BASE, CMD_START_LAST));
        else if (r < 54) cmd = CMD_MUX_RATIO;
        else if (r < 58) cmd = CMD_OFFSET;
        else if (r < 62) cmd = CMD_DISPLAY_OFF;
        else if (r < 80) begin
            case ($urandom_range(0, 8))
                0: cmd = CMD_SCROLL_OFF;
                1: cmd = CMD_SCROLL_ON;
                2: cmd = CMD_ENTIRE_OFF;
                3: cmd = CMD_ENTIRE_ON;
                4: cmd = CMD_NORMAL;
                5: cmd = CMD_INVERT;
                6: cmd = CMD_DISPLAY_ON;
                7: cmd = CMD_COM_NORMAL;
                default: cmd = CMD_COM_REVERSE;
            endcase
        end else if (r < 90) begin
            case ($urandom_range(0, 10))
                0: cmd = CMD_CONTRAST;
                1: cmd = CMD_CHARGE_PUMP;
                2: cmd = CMD_VSCROLL_AREA;
                3: cmd = CMD_HSCROLL_R;
                4: cmd = CMD_HSCROLL_L;
                5: cmd = CMD_VHSCROLL_R;
                6: cmd = CMD_VHSCROLL_L;
                7: cmd = CMD_CLOCK_DIV;
                8: cmd = CMD_PRECHARGE;
                9: cmd = CMD_COM_PINS;
                default: cmd = CMD_VCOMH;
            endcase
        end else begin
            cmd = 8'($urandom_range(0, 255));
        end
        case (cmd)
            CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MUX_RATIO, CMD_OFFSET,
            CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOMH: n = 1;
            CMD_COL_WINDOW, CMD_PAGE_WINDOW, CMD_VSCROLL_AREA: n = 2;
            CMD_HSCROLL_R, CMD_HSCROLL_L: n = 6;
            CMD_VHSCROLL_R, CMD_VHSCROLL_L: n = 5;
            default: n = 0;
        endcase
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
        send_rx(cmd);
        for (int i = 0; i < n; i++) begin
            p = 8'($urandom_range(0, 255));
            // Narrow column windows make the wrap happen within a short burst.
            if (cmd == CMD_COL_WINDOW && i == 1 && $urandom_range(0, 1) == 1)
                p[6:0] = prev[6:0] + 7'($urandom_range(0, 15));
            prev = p;
            send_rx(p);
        end
    endtask

    // Occasionally a control byte that keeps the decoder on control bytes goes
    // first, as a continuation would.
    task automatic open_transaction(logic [7:0] ctrl);
        send_start();
        if ($urandom_range(0, 7) == 0)
            send_rx(CTRL_CONTINUE | ($urandom_range(0, 1) == 1 ? CTRL_DATA : CTRL_COMMAND));
        send_rx(ctrl);
    endtask

    // Mostly well formed transactions with random content; the rest are scan
    // reads and raw noise, which also yields broken control bytes, bytes
    // without a start and starts in the middle of a parameter list.
    task automatic random_transaction();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            open_transaction(CTRL_COMMAND);
            repeat ($urandom_range(1, 6)) send_random_command();
        end else if (kind < 80) begin
            open_transaction(CTRL_DATA);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
            repeat (n) send_rx(8'($urandom_range(0, 255)));
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 4)) send_scan();
        end else begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
        end
    endtask

    // Writes the column count register and then the page count register.
    task automatic write_panel_size(logic [7:0] cols, logic [7:0] pages);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COLUMNS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        board.set_size(CFG_COLUMNS, cols);
        i_cfg_idx  <= CFG_PAGES;
        i_cfg_data <= pages;
        @(posedge i_clk);
        board.set_size(CFG_PAGES, pages);
        i_cfg_we   <= 1'b0;
    endtask

    // Directed opening: unused item kind, a byte before any start, a control
    // byte with reserved bits, both column nibbles with the dropped high bit,
    // the last page and start line, a mux ratio just below and at the minimum,
    // the largest offset, the flag commands, a window in page mode that must be
    // ignored, an unknown command, and data at the last column that wraps back.
    task automatic directed_opening();
        send_item(FUNC_UNUSED, 8'hA5, 7'h7F, 3'd7);
        send_byte(CMD_DISPLAY_ON);
        send_start();
        send_byte(CTRL_CONTINUE | CTRL_DATA | CTRL_RESERVED);
        send_byte(CTRL_COMMAND);
        send_byte(CMD_COL_HI_BASE - 8'd1);
        send_byte(CMD_LOW_END - 8'd1);
        send_byte(CMD_PAGE_LAST);
        send_byte(CMD_START_LAST);
        send_byte(CMD_MUX_RATIO);
        send_byte(8'(MUX_MIN) - 8'd1);
        send_byte(CMD_MUX_RATIO);
        send_byte(8'(MUX_MIN));
        send_byte(CMD_OFFSET);
        send_byte(8'hFF);
        send_byte(CMD_ENTIRE_ON);
        send_byte(CMD_INVERT);
        send_byte(CMD_COM_REVERSE);
        send_byte(CMD_SCROLL_ON);
        send_byte(CMD_COL_WINDOW);
        send_byte(8'h05);
        send_byte(8'h06);
        send_byte(CMD_UNKNOWN);
        send_start();
        send_byte(CTRL_DATA);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_item(FUNC_SCAN, 8'h00, 7'h7F, 3'd7);
        send_item(FUNC_SCAN, 8'hFF, 7'h00, 3'd7);
    endtask

    // Result side: stalls drawn per item, plus one long hold-off on request so
    // that the result register stays full and the block backs up its input.
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (board.results_seen % 50 == 0) take_style = $urandom_range(0, 2);
            if (hold_results) begin
                hold_results = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = draw_wait(take_style);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            board.check_status(m_tdata);
        end
    end

    // Main sequence. After reset the block clears its RAM first; the first item
    // simply waits for the ready. Each phase sets a new panel size while the
    // block is idle and then issues a display off so the new size reaches the
    // window bounds. The sizes include both ends of the legal range and values
    // that are clamped.
    initial begin : stimulus
        logic [7:0] col_sizes [NUM_PHASES];
        logic [7:0] page_sizes [NUM_PHASES];
        int         target;
        col_sizes  = '{8'd128, 8'd32, 8'd255, 8'd0, 8'd100, 8'd64};
        page_sizes = '{8'd8, 8'd2, 8'd255, 8'd0, 8'd5, 8'd3};
        col_sizes[NUM_PHASES-1]  = 8'($urandom_range(0, 255));
        page_sizes[NUM_PHASES-1] = 8'($urandom_range(0, 15));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_opening();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_panel_size(col_sizes[ph], page_sizes[ph]);
            @(posedge i_clk);
            send_start();
            send_byte(CTRL_COMMAND);
            send_byte(CMD_DISPLAY_OFF);
            // In the third phase the result side holds off for a long stretch
            // while items keep being offered back to back.
            if (ph == 2) begin
                send_style   = 0;
                hold_results = 1'b1;
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) random_transaction();
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("[oled_controller_command_decoder_unit] OK");
        end else begin
            $display("[oled_controller_command_decoder_unit] ERROR");
        end
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("[oled_controller_command_decoder_unit] ERROR");
        $finish;
    end

endmodule
